// File: hdl/wms_pkg.sv
// Shared widths and constants for the window measurement statistics block.
package wms_pkg;

    localparam int SAMPLE_W             = 24;
    localparam int COUNT_W              = 5;
    localparam int RATIO_W              = 17;
    localparam int DEFAULT_WINDOW_DEPTH = 16;

    // Q1.16 unity and the fixed confidence of an empty window (0.35)
    localparam int Q_ONE      = 65536;
    localparam int EMPTY_CONF = 22937;

    // threshold factors in percent of the mean
    localparam int PCT_SCALE   = 100;
    localparam int PCT_SAMPLE  = 35;
    localparam int PCT_SPIKE   = 25;
    localparam int PCT_OUTLIER = 45;
    localparam int PCT_DRIFT   = 8;
    localparam int STEP_NUM    = 3;
    localparam int STEP_DEN    = 10;

    // confidence score terms
    localparam int CONF_BASE   = 16384;
    localparam int CONF_FILL   = 786432;
    localparam int CONF_JIT    = 5;
    localparam int CONF_OUTL   = 131072;
    localparam int CONF_DEN    = 20;
    localparam int OUTL_CAP    = 10;
    localparam int DRIFT_MIN_N = 5;
    localparam int STEP_MIN_N  = 3;

endpackage

// File: hdl/wms_ram.sv
// Generic single write port, single read port RAM with registered read data.
module wms_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/wms_div.sv
// Restoring divider, one quotient bit per cycle.
module wms_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0] trial;
    logic           fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // control
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: hdl/wms_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module wms_sqrt #(
    parameter int RAD_W = 96
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [RAD_W-1:0]   radicand,
    output logic [RAD_W/2-1:0] root,
    output logic               done
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ROOT_W+3:0] cur;
    logic [ROOT_W+3:0] trial;
    logic              fits;

    assign cur   = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = cur >= trial;

    // control
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // two radicand bits in, one root bit out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            rem_reg  <= fits ? (ROOT_W+2)'(cur - trial) : (ROOT_W+2)'(cur);
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// File: hdl/window_measurement_statistics_top.sv
// Top level: sequencer and datapath of the window measurement statistics block.
// An empty window's result is valid in the cycle after the transfer; otherwise the
//   sequencer runs two passes over the window, the setup states, one root and three
//   divides; the jitter divide is skipped when the jitter clamps to one.
// Throughput: one sample per result; the input stalls until the result is taken.
// Reset clears fill count, write position and sequencer; window contents need none.
module window_measurement_statistics_top #(
    parameter int WINDOW_DEPTH = wms_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [wms_pkg::SAMPLE_W-1:0] sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [wms_pkg::COUNT_W-1:0]         entry_count,
    output logic [wms_pkg::SAMPLE_W-1:0]        last_residual,
    output logic [wms_pkg::SAMPLE_W-1:0]        mean_step,
    output logic [wms_pkg::RATIO_W-1:0]         jitter,
    output logic [wms_pkg::RATIO_W-1:0]         spike_rate,
    output logic [wms_pkg::COUNT_W-1:0]         outlier_total,
    output logic                                step_change,
    output logic                                drift,
    output logic [wms_pkg::RATIO_W-1:0]         confidence
);

    localparam int XW  = wms_pkg::SAMPLE_W;
    localparam int AW  = $clog2(WINDOW_DEPTH);
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW  = XW + CW;            // signed window sum
    localparam int QW  = 2 * XW - 1 + CW;    // sum of squares
    localparam int DW  = 2 * SW;             // variance numerator
    localparam int NW  = DW + 32;            // radicand, d scaled by 2^32
    localparam int RW  = NW / 2;             // root and dividend width
    localparam int MW  = SW + 1;             // divisor width
    localparam int TW  = SW + CW + 9;        // threshold compare width
    localparam int RTW = wms_pkg::RATIO_W;

    localparam int C_CONF_BASE = wms_pkg::CONF_DEN * WINDOW_DEPTH * wms_pkg::CONF_BASE;
    localparam int C_JIT       = wms_pkg::CONF_JIT * WINDOW_DEPTH;
    localparam int C_OUTL      = wms_pkg::CONF_OUTL * WINDOW_DEPTH;
    localparam int C_CDIV      = wms_pkg::CONF_DEN * WINDOW_DEPTH;

    // score divide by 20*W: numerator over four (below 2^25 up to depth 64),
    // then a reciprocal multiply exact for every such numerator
    localparam int     CNW        = 25;
    localparam int     RCW        = 31;
    localparam int     CONF_SHIFT = 34;
    localparam int     CQW        = CNW + RCW - CONF_SHIFT;
    localparam int     C_CDIV4    = C_CDIV / 4;
    localparam longint RECIP      = ((longint'(1) << CONF_SHIFT) + longint'(C_CDIV4) - 1)
                                    / longint'(C_CDIV4);
    localparam logic [RCW-1:0] K_RECIP = RCW'(RECIP);

    localparam logic [TW-1:0] K_SCALE = TW'(wms_pkg::PCT_SCALE);
    localparam logic [TW-1:0] K_SMP   = TW'(wms_pkg::PCT_SAMPLE);
    localparam logic [TW-1:0] K_SPK   = TW'(wms_pkg::PCT_SPIKE);
    localparam logic [TW-1:0] K_OUT   = TW'(wms_pkg::PCT_OUTLIER);
    localparam logic [TW-1:0] K_DRF   = TW'(wms_pkg::PCT_DRIFT);
    localparam logic [TW-1:0] K_SNUM  = TW'(wms_pkg::STEP_NUM);
    localparam logic [TW-1:0] K_SDEN  = TW'(wms_pkg::STEP_DEN);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PASS1 = 14'b00000000000010,
        S_PREP1 = 14'b00000000000100,
        S_PREP2 = 14'b00000000001000,
        S_PREP3 = 14'b00000000010000,
        S_PREP4 = 14'b00000000100000,
        S_PASS2 = 14'b00000001000000,
        S_SQRT  = 14'b00000010000000,
        S_JDIV  = 14'b00000100000000,
        S_MDIV  = 14'b00001000000000,
        S_RDIV  = 14'b00010000000000,
        S_CONF  = 14'b00100000000000,
        S_CDIV  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // control registers
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] start_reg, start_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // datapath registers
    logic signed [XW-1:0] x_reg, prev_reg, last_reg;
    logic [CW-1:0]        n_reg, spikes_reg, outl_reg;
    logic signed [SW-1:0] s_reg;
    logic [QW-1:0]        sq_reg;
    logic [SW-1:0]        abs_sum_reg, as_reg;
    logic [XW-1:0]        res_reg;
    logic [DW-1:0]        ss_reg, nsq_reg, d_reg;
    logic signed [SW:0]   nx_reg;
    logic [MW-1:0]        m_reg;
    logic [2*MW-1:0]      mm_reg;
    logic [CW+XW-1:0]     nres_reg;
    logic [TW-1:0]        thr_sp_reg, thr_out_reg;
    logic [RTW-1:0]       jit_reg;
    logic [CNW-1:0]       conf_num_reg;

    logic [wms_pkg::COUNT_W-1:0] o_count_reg, o_outl_reg;
    logic [XW-1:0]               o_res_reg, o_mstep_reg;
    logic [RTW-1:0]              o_jit_reg, o_rate_reg, o_conf_reg;
    logic                        o_step_reg, o_drift_reg;

    // window memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [XW-1:0] ram_wdata, ram_rdata;

    wms_ram #(
        .WIDTH (XW),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // shared units
    logic          div_start, div_done, sqrt_start, sqrt_done;
    logic [RW-1:0] div_a, div_q, sqrt_root;
    logic [MW-1:0] div_b;

    wms_div #(
        .NUM_W (RW),
        .DEN_W (MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    wms_sqrt #(
        .RAD_W (NW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({d_reg, 32'd0}),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    logic in_xfer;
    assign in_xfer = sample_valid && (state_reg == S_IDLE);

    // per-entry pass arithmetic
    logic signed [XW-1:0]   rd_v;
    logic signed [XW:0]     step_diff;
    logic [XW:0]            step_abs;
    logic signed [2*XW-1:0] v_prod;
    logic [CW+XW:0]         n_delta;
    logic [TW-1:0]          nd100, n100;

    assign rd_v      = $signed(ram_rdata);
    assign step_diff = {rd_v[XW-1], rd_v} - {prev_reg[XW-1], prev_reg};
    assign step_abs  = step_diff[XW] ? $unsigned(-step_diff) : $unsigned(step_diff);
    assign v_prod    = rd_v * rd_v;
    assign n_delta   = n_reg * step_abs;
    assign nd100     = TW'(n_delta) * K_SCALE;
    assign n100      = TW'(n_reg) * K_SCALE;

    // setup arithmetic
    logic signed [XW:0]     res_diff;
    logic signed [DW-1:0]   s_prod;
    logic [CW+QW-1:0]       n_sq;
    logic signed [SW:0]     n_x;
    logic signed [SW+1:0]   dev;
    logic [SW+1:0]          dev_abs;
    logic [CW+XW-1:0]       n_res;

    assign res_diff = {x_reg[XW-1], x_reg} - {last_reg[XW-1], last_reg};
    assign s_prod   = s_reg * s_reg;
    assign n_sq     = n_reg * sq_reg;
    assign n_x      = $signed({1'b0, n_reg}) * x_reg;
    assign dev      = {nx_reg[SW], nx_reg} - {{2{s_reg[SW-1]}}, s_reg};
    assign dev_abs  = dev[SW+1] ? $unsigned(-dev) : $unsigned(dev);
    assign n_res    = n_reg * res_reg;

    // flags and confidence numerator
    logic             step_flag, drift_flag;
    logic [3:0]       omin;
    logic signed [31:0] conf_t;

    assign step_flag = (int'(n_reg) >= wms_pkg::STEP_MIN_N)
                       && (TW'(nres_reg) * K_SDEN > TW'(as_reg) * K_SNUM);
    assign drift_flag = (int'(n_reg) >= wms_pkg::DRIFT_MIN_N) && !step_flag
                        && ({3'b000, jit_reg} * 20'd5 < 20'(wms_pkg::Q_ONE))
                        && (TW'(nres_reg) * K_SCALE > TW'(as_reg) * K_DRF);
    assign omin   = (int'(outl_reg) > wms_pkg::OUTL_CAP) ? 4'(wms_pkg::OUTL_CAP)
                                                        : 4'(outl_reg);
    assign conf_t = 32'(C_CONF_BASE + wms_pkg::CONF_FILL * int'(n_reg)
                        - C_JIT * int'(jit_reg) - C_OUTL * int'(omin));

    // confidence quotient by reciprocal multiply
    logic [CNW+RCW-1:0] conf_prod;
    logic [CQW-1:0]     conf_q;

    assign conf_prod = (CNW+RCW)'(conf_num_reg) * (CNW+RCW)'(K_RECIP);
    assign conf_q    = conf_prod[CNW+RCW-1:CONF_SHIFT];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        ptr_next   = ptr_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_waddr  = wp_reg;
        ram_wdata  = x_reg;
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;
        sqrt_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    if (fill_reg == '0)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = sample;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        if (int'(wp_reg) >= int'(fill_reg))
                        begin
                            start_next = AW'(int'(wp_reg) - int'(fill_reg));
                        end
                        else
                        begin
                            start_next = AW'(int'(wp_reg) + WINDOW_DEPTH - int'(fill_reg));
                        end
                        ptr_next   = start_next;
                        cnt_next   = '0;
                        state_next = S_PASS1;
                    end
                end
            end
            S_PASS1, S_PASS2:
            begin
                ptr_next = (ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == n_reg)
                begin
                    if (state_reg == S_PASS1)
                    begin
                        state_next = S_PREP1;
                    end
                    else
                    begin
                        sqrt_start = 1'b1;
                        state_next = S_SQRT;
                    end
                end
            end
            S_PREP1:
            begin
                state_next = S_PREP2;
            end
            S_PREP2:
            begin
                state_next = S_PREP3;
            end
            S_PREP3:
            begin
                state_next = S_PREP4;
            end
            S_PREP4:
            begin
                ptr_next   = start_reg;
                cnt_next   = '0;
                state_next = S_PASS2;
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    div_start = 1'b1;
                    if ((2*MW)'(d_reg) >= mm_reg)
                    begin
                        div_a      = RW'(abs_sum_reg);
                        div_b      = (n_reg > CW'(1)) ? MW'(n_reg - 1'b1) : MW'(1);
                        state_next = S_MDIV;
                    end
                    else
                    begin
                        div_a      = sqrt_root;
                        div_b      = m_reg;
                        state_next = S_JDIV;
                    end
                end
            end
            S_JDIV:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_a      = RW'(abs_sum_reg);
                    div_b      = (n_reg > CW'(1)) ? MW'(n_reg - 1'b1) : MW'(1);
                    state_next = S_MDIV;
                end
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_a      = RW'({spikes_reg, 16'd0});
                    div_b      = MW'(n_reg);
                    state_next = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    state_next = S_CONF;
                end
            end
            S_CONF:
            begin
                state_next = S_CDIV;
            end
            S_CDIV:
            begin
                ram_we     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // window bookkeeping follows every store
        if (ram_we)
        begin
            wp_next   = (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            fill_next = (fill_reg == CW'(WINDOW_DEPTH)) ? fill_reg : fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            wp_reg    <= '0;
            ptr_reg   <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            wp_reg    <= wp_next;
            ptr_reg   <= ptr_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg       <= sample;
                n_reg       <= fill_reg;
                s_reg       <= '0;
                sq_reg      <= '0;
                abs_sum_reg <= '0;
                spikes_reg  <= '0;
                outl_reg    <= '0;
                if (in_xfer && fill_reg == '0)
                begin
                    o_count_reg <= wms_pkg::COUNT_W'(1);
                    o_res_reg   <= '0;
                    o_mstep_reg <= '0;
                    o_jit_reg   <= '0;
                    o_rate_reg  <= '0;
                    o_outl_reg  <= '0;
                    o_step_reg  <= 1'b0;
                    o_drift_reg <= 1'b0;
                    o_conf_reg  <= RTW'(wms_pkg::EMPTY_CONF);
                end
            end
            S_PASS1:
            begin
                if (cnt_reg != '0)
                begin
                    s_reg    <= s_reg + SW'(rd_v);
                    sq_reg   <= sq_reg + QW'($unsigned(v_prod));
                    prev_reg <= rd_v;
                    last_reg <= rd_v;
                    if (cnt_reg >= CW'(2))
                    begin
                        abs_sum_reg <= abs_sum_reg + SW'(step_abs);
                    end
                end
            end
            S_PREP1:
            begin
                as_reg  <= s_reg[SW-1] ? $unsigned(-s_reg) : $unsigned(s_reg);
                res_reg <= res_diff[XW] ? XW'($unsigned(-res_diff)) : XW'($unsigned(res_diff));
                ss_reg  <= $unsigned(s_prod);
            end
            S_PREP2:
            begin
                nsq_reg <= DW'(n_sq);
                nx_reg  <= n_x;
                m_reg   <= MW'(as_reg) + MW'(n_reg);
            end
            S_PREP3:
            begin
                d_reg       <= (nsq_reg >= ss_reg) ? nsq_reg - ss_reg : '0;
                thr_sp_reg  <= TW'(as_reg) * K_SPK + n100;
                thr_out_reg <= TW'(as_reg) * K_OUT + n100;
                // current sample against the window mean
                if (TW'(dev_abs) * K_SCALE > TW'(as_reg) * K_SMP + n100)
                begin
                    spikes_reg <= spikes_reg + 1'b1;
                    outl_reg   <= outl_reg + 1'b1;
                end
            end
            S_PREP4:
            begin
                mm_reg   <= m_reg * m_reg;
                nres_reg <= n_res;
            end
            S_PASS2:
            begin
                if (cnt_reg != '0)
                begin
                    prev_reg <= rd_v;
                    if (cnt_reg >= CW'(2))
                    begin
                        if (nd100 > thr_sp_reg)
                        begin
                            spikes_reg <= spikes_reg + 1'b1;
                        end
                        if (nd100 > thr_out_reg)
                        begin
                            outl_reg <= outl_reg + 1'b1;
                        end
                    end
                end
            end
            S_SQRT:
            begin
                if (sqrt_done && (2*MW)'(d_reg) >= mm_reg)
                begin
                    jit_reg <= RTW'(wms_pkg::Q_ONE);
                end
            end
            S_JDIV:
            begin
                if (div_done)
                begin
                    jit_reg <= RTW'(div_q);
                end
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    o_mstep_reg <= XW'(div_q);
                end
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    o_rate_reg <= RTW'(div_q);
                end
            end
            S_CONF:
            begin
                o_count_reg  <= wms_pkg::COUNT_W'(n_reg + 1'b1);
                o_res_reg    <= res_reg;
                o_jit_reg    <= jit_reg;
                o_outl_reg   <= wms_pkg::COUNT_W'(outl_reg);
                o_step_reg   <= step_flag;
                o_drift_reg  <= drift_flag;
                conf_num_reg <= (conf_t > 0) ? CNW'($unsigned(conf_t) >> 2) : '0;
            end
            S_CDIV:
            begin
                o_conf_reg <= (conf_q > CQW'(wms_pkg::Q_ONE)) ? RTW'(wms_pkg::Q_ONE)
                                                               : RTW'(conf_q);
            end
            S_OUT:
            begin
                prev_reg <= prev_reg;
            end
            default:
            begin
                prev_reg <= prev_reg;
            end
        endcase
    end

    // ports
    assign sample_stall  = (state_reg != S_IDLE);
    assign result_valid  = (state_reg == S_OUT);
    assign entry_count   = o_count_reg;
    assign last_residual = o_res_reg;
    assign mean_step     = o_mstep_reg;
    assign jitter        = o_jit_reg;
    assign spike_rate    = o_rate_reg;
    assign outlier_total = o_outl_reg;
    assign step_change   = o_step_reg;
    assign drift         = o_drift_reg;
    assign confidence    = o_conf_reg;

endmodule

// File: tb/window_measurement_statistics_top_test.sv
// Self-checking testbench for the window measurement statistics block.
module window_measurement_statistics_top_test;

    localparam int SAMPLE_W    = wms_pkg::SAMPLE_W;
    localparam int COUNT_W     = wms_pkg::COUNT_W;
    localparam int RATIO_W     = wms_pkg::RATIO_W;
    localparam int Q_ONE       = wms_pkg::Q_ONE;
    localparam int EMPTY_CONF  = wms_pkg::EMPTY_CONF;
    localparam int CONF_BASE   = wms_pkg::CONF_BASE;
    localparam int CONF_FILL   = wms_pkg::CONF_FILL;
    localparam int CONF_OUTL   = wms_pkg::CONF_OUTL;
    localparam int OUTL_CAP    = wms_pkg::OUTL_CAP;
    localparam int STEP_MIN_N  = wms_pkg::STEP_MIN_N;
    localparam int DRIFT_MIN_N = wms_pkg::DRIFT_MIN_N;

    localparam int DEPTH      = wms_pkg::DEFAULT_WINDOW_DEPTH;
    localparam int N_RANDOM   = 830;
    localparam int CYCLE_CAP  = 2000000;

    // one result of the block
    typedef struct packed {
        logic [COUNT_W-1:0]  cnt;
        logic [SAMPLE_W-1:0] resid;
        logic [SAMPLE_W-1:0] mstep;
        logic [RATIO_W-1:0]  jit;
        logic [RATIO_W-1:0]  spk;
        logic [COUNT_W-1:0]  outl;
        logic                stp;
        logic                drf;
        logic [RATIO_W-1:0]  conf;
    } stats_t;

    // window predictor plus queue of pending statistics
    class stats_scoreboard;
        longint win[DEPTH];
        int     fill;
        int     wpos;
        stats_t pending[$];
        int     errors;

        function new();
            foreach (win[i]) win[i] = 0;
            fill = 0;
            wpos = 0;
            errors = 0;
        endfunction

        function longint entry(int i);
            return win[(wpos + DEPTH - fill + i) % DEPTH];
        endfunction

        // floor(65536*sqrt(d)/m) clamped, by bitwise search
        function longint root_ratio(longint d, longint m);
            logic [127:0] p;
            longint q, t;
            q = 0;
            if (d >= m * m) return Q_ONE;
            for (int b = 15; b >= 0; b--)
            begin
                t = q | (64'd1 << b);
                p = 128'(t * m) * 128'(t * m);
                if (p <= (128'(d) << 32)) q = t;
            end
            return q;
        endfunction

        function longint absl(longint v);
            return v < 0 ? -v : v;
        endfunction

        // note an accepted sample transfer
        function void note_sample(logic [SAMPLE_W-1:0] raw);
            stats_t e;
            longint x, n, s, sq, as, res, asum, dl, dd, tot;
            longint jit, spikes, outl, conf;
            e = '0;
            x = longint'($signed(raw));
            n = fill;
            if (fill == 0)
            begin
                e.cnt = COUNT_W'(1);
                e.conf = RATIO_W'(EMPTY_CONF);
            end
            else
            begin
                s = 0; sq = 0; asum = 0; spikes = 0; outl = 0;
                res = absl(x - win[(wpos + DEPTH - 1) % DEPTH]);
                for (int i = 0; i < fill; i++)
                begin
                    s += entry(i);
                    sq += entry(i) * entry(i);
                end
                as = absl(s);
                dd = n * sq - s * s;
                if (dd < 0) dd = 0;
                jit = root_ratio(dd, as + n);
                if (100 * absl(n * x - s) > 35 * as + 100 * n)
                begin
                    spikes++;
                    outl++;
                end
                for (int i = 1; i < fill; i++)
                begin
                    dl = absl(entry(i) - entry(i - 1));
                    asum += dl;
                    if (100 * n * dl > 25 * as + 100 * n) spikes++;
                    if (100 * n * dl > 45 * as + 100 * n) outl++;
                end
                e.stp = (n >= STEP_MIN_N) && (10 * n * res > 3 * as);
                e.drf = (n >= DRIFT_MIN_N) && !e.stp && (jit * 5 < Q_ONE)
                        && (100 * n * res > 8 * as);
                tot = 20 * DEPTH * CONF_BASE + CONF_FILL * n - 5 * DEPTH * jit
                      - CONF_OUTL * DEPTH * (outl > OUTL_CAP ? OUTL_CAP : outl);
                conf = tot <= 0 ? 0 : tot / (20 * DEPTH);
                if (conf > Q_ONE) conf = Q_ONE;
                e.cnt = COUNT_W'(n + 1);
                e.resid = SAMPLE_W'(res);
                e.mstep = SAMPLE_W'(asum / (n > 1 ? n - 1 : 1));
                e.jit = RATIO_W'(jit);
                e.spk = RATIO_W'(spikes * Q_ONE / n);
                e.outl = COUNT_W'(outl);
                e.conf = RATIO_W'(conf);
            end
            pending.push_back(e);
            win[wpos] = x;
            wpos = (wpos + 1) % DEPTH;
            if (fill < DEPTH) fill++;
        endfunction

        // compare a result transfer with the oldest prediction
        function void check_result(stats_t got);
            stats_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                $display("%0t: mismatch expected %p actual %p", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    stats_t              got;
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    longint              cycles = 0;
    int                  items = 0;
    stats_scoreboard     sb;

    window_measurement_statistics_top #(.WINDOW_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall),
        .entry_count(got.cnt), .last_residual(got.resid), .mean_step(got.mstep),
        .jitter(got.jit), .spike_rate(got.spk), .outlier_total(got.outl),
        .step_change(got.stp), .drift(got.drf), .confidence(got.conf)
    );

    always #4 clk = ~clk;

    // result side: random stall, check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall) sb.check_result(got);
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // offer one sample and hold it until transferred; valid stays up afterwards
    // so that a following sample can go out back to back
    task automatic send_sample(logic [SAMPLE_W-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= v;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        sb.note_sample(v);
        items++;
    endtask

    // random sample: mostly a noisy level, sometimes full range or a jump
    function automatic logic [SAMPLE_W-1:0] pick_sample(ref longint level);
        int r;
        r = $urandom_range(99);
        if (r < 5) level = longint'($signed(SAMPLE_W'($urandom)));
        else if (r < 10) level = longint'($urandom_range(2000)) - 1000;
        if (r < 15) return SAMPLE_W'($urandom);
        if (r < 25) return SAMPLE_W'(level + ($urandom_range(1) ? 1 : -1) * level / 2);
        return SAMPLE_W'(level + longint'($urandom_range(200)) - 100);
    endfunction

    initial
    begin
        longint level;
        int spans[4];
        int stalls[4];
        spans = '{0, 53, 0, 8};
        stalls = '{0, 0, 53, 8};
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty window, extremes, zeros, flat run, step, outlier
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        send_sample(24'h000001);
        repeat (6) send_sample(24'h000000);
        repeat (5) send_sample(24'd1000);
        send_sample(24'd1003);
        send_sample(24'd5000);
        send_sample(-24'sd5000);
        repeat (4) send_sample(24'h800000);

        // random phases with different idle and stall mixes
        level = 1000;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = spans[ph];
            stall_pct = stalls[ph];
            for (int k = 0; k < N_RANDOM / 4; k++)
                send_sample(pick_sample(level));
        end
        sample_valid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Sent %0d samples: full-scale extremes, flat runs, steps and noisy levels,",
                 items);
        $display("under mixed sender gaps and receiver stalls.");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
hdl/wms_pkg.sv
hdl/wms_ram.sv
hdl/wms_div.sv
hdl/wms_sqrt.sv
hdl/window_measurement_statistics_top.sv
tb/window_measurement_statistics_top_test.sv
